>>> src/mmf_pkg.sv
// ----------------------------------------------------------------------------
// mmf_pkg: shared types and constants for the 3x3 min/max morphology filter
// Field widths, register indexes and the window select struct.
// ----------------------------------------------------------------------------
package mmf_pkg;

    // Field widths of the result word and of the size registers
    localparam int ROW_W = 12;
    localparam int COL_W = 10;
    localparam int FR_W  = 13;
    localparam int FC_W  = 11;
    localparam int CFG_W = 13;
    localparam int IDX_W = 2;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_COLS   = 1024;
    localparam int DEF_MAX_ROWS   = 4096;
    localparam int DEF_PIXEL_BITS = 16;

    // Window geometry: 3x3, row-major, bottom-right entry is the newest pixel
    localparam int WIN_N = 9;

    // Results one pixel can cause
    localparam int RES_N = 4;

    typedef enum logic [IDX_W-1:0] {
        CFG_MODE = 2'd0,
        CFG_ROWS = 2'd1,
        CFG_COLS = 2'd2
    } t_cfg_idx;

    // Which part of the window a result reduces over
    typedef struct packed {
        logic       use_max;
        logic [1:0] row_lo;
        logic [1:0] col_lo;
    } t_win_sel;

endpackage

>>> src/mmf_ram.sv
// ----------------------------------------------------------------------------
// mmf_ram: generic single-clock RAM
// One write port, one read port, registered read data (old data on collision).
// ----------------------------------------------------------------------------
module mmf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/mmf_reduce.sv
// ----------------------------------------------------------------------------
// mmf_reduce: 3x3 window minimum / maximum
// Reduces the window entries at or below row_lo and at or right of col_lo.
// ----------------------------------------------------------------------------
module mmf_reduce #(
    parameter int PIXEL_BITS = 16
) (
    input  mmf_pkg::t_win_sel                               i_sel,
    input  logic [mmf_pkg::WIN_N-1:0][PIXEL_BITS-1:0]       i_win,
    output logic [PIXEL_BITS-1:0]                           o_value
);
    import mmf_pkg::*;

    logic [WIN_N-1:0][PIXEL_BITS-1:0] v;
    logic [3:0][PIXEL_BITS-1:0]       l1;
    logic [1:0][PIXEL_BITS-1:0]       l2;
    logic [PIXEL_BITS-1:0]            l3;

    function automatic logic [PIXEL_BITS-1:0] pick(
        input logic                  use_max,
        input logic [PIXEL_BITS-1:0] a,
        input logic [PIXEL_BITS-1:0] b
    );
        logic take_a;
        take_a = use_max ? (a > b) : (a < b);
        return take_a ? a : b;
    endfunction

    // Excluded entries read as the newest pixel, which is always included
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
                if ((2'(a) >= i_sel.row_lo) && (2'(b) >= i_sel.col_lo)) begin
                    v[a*3+b] = i_win[a*3+b];
                end else begin
                    v[a*3+b] = i_win[WIN_N-1];
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            l1[i] = pick(i_sel.use_max, v[2*i], v[2*i+1]);
        end
        for (int j = 0; j < 2; j++) begin
            l2[j] = pick(i_sel.use_max, l1[2*j], l1[2*j+1]);
        end
        l3      = pick(i_sel.use_max, l2[0], l2[1]);
        o_value = pick(i_sel.use_max, l3, v[WIN_N-1]);
    end

endmodule

>>> src/morphology_3x3_min_max_filter.sv
// ----------------------------------------------------------------------------
// morphology_3x3_min_max_filter: streaming 3x3 grayscale erosion / dilation
// Raster-order pixels in, 3x3 min or max with row/column tags out.
// ----------------------------------------------------------------------------
//  channel   | handshake                          | payload
//  ----------+------------------------------------+---------------------------
//  pixel in  | i_pixel_valid / o_pixel_ready      | i_pixel
//  result out| o_result_valid / i_result_ready    | o_result_value, _row, _col,
//            |                                    | o_last_of_run, o_frame_done
//  config    | i_cfg_we (no wait, no read-back)   | i_cfg_idx, i_cfg_data
//
//  One pixel per clock while the result side keeps up. A pixel passes the
//  line-buffer read, window and result registers before its result shows. On
//  the last column or the last row a pixel makes up to 4 results, one per
//  cycle while the receiver is ready, and the window stage holds the input.
//  Reset is synchronous; line buffers are not cleared (unwritten words go unused).
//  A stalled result backs up through the window and read stages to ready.
// ----------------------------------------------------------------------------
module morphology_3x3_min_max_filter #(
    parameter int MAX_COLS   = mmf_pkg::DEF_MAX_COLS,    // 4..1024
    parameter int MAX_ROWS   = mmf_pkg::DEF_MAX_ROWS,    // 1..4096
    parameter int PIXEL_BITS = mmf_pkg::DEF_PIXEL_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [mmf_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [mmf_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_pixel_valid,
    output logic                        o_pixel_ready,
    input  logic [PIXEL_BITS-1:0]       i_pixel,
    output logic                        o_result_valid,
    input  logic                        i_result_ready,
    output logic [PIXEL_BITS-1:0]       o_result_value,
    output logic [mmf_pkg::ROW_W-1:0]   o_result_row,
    output logic [mmf_pkg::COL_W-1:0]   o_result_col,
    output logic                        o_last_of_run,
    output logic                        o_frame_done
);
    import mmf_pkg::*;

    localparam int AW       = $clog2(MAX_COLS);
    localparam int LW       = 2 * PIXEL_BITS;
    localparam int ROWS_RST = (MAX_ROWS < 4096) ? MAX_ROWS : 4096;
    localparam int COLS_RST = (MAX_COLS < 1024) ? MAX_COLS : 1024;

    // ------------------------------------------------------------------
    // Configuration and frame counters
    // ------------------------------------------------------------------
    logic             r_mode;
    logic [FR_W-1:0]  r_frame_rows;
    logic [FC_W-1:0]  r_frame_cols;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] n_row;
    logic [COL_W-1:0] n_col;
    logic [FR_W-1:0]  cfg_rows;
    logic [FC_W-1:0]  cfg_cols;

    logic             in_acc;
    logic [ROW_W-1:0] cur_r;
    logic [COL_W-1:0] cur_c;
    logic             cur_last_row;
    logic             cur_last_col;

    // Clamp size writes to 1..max
    always_comb begin
        cfg_rows = i_cfg_data[FR_W-1:0];
        if (cfg_rows == '0) begin
            cfg_rows = FR_W'(1);
        end else if (32'(i_cfg_data[FR_W-1:0]) > 32'(MAX_ROWS)) begin
            cfg_rows = FR_W'(MAX_ROWS);
        end
        cfg_cols = i_cfg_data[FC_W-1:0];
        if (cfg_cols == '0) begin
            cfg_cols = FC_W'(1);
        end else if (32'(i_cfg_data[FC_W-1:0]) > 32'(MAX_COLS)) begin
            cfg_cols = FC_W'(MAX_COLS);
        end
    end

    assign in_acc = i_pixel_valid && o_pixel_ready;

    always_comb begin
        cur_r = ({1'b0, r_row} >= r_frame_rows) ? '0 : r_row;
        cur_c = ({1'b0, r_col} >= r_frame_cols) ? '0 : r_col;
        cur_last_row = (({1'b0, cur_r} + FR_W'(1)) == r_frame_rows);
        cur_last_col = (({1'b0, cur_c} + FC_W'(1)) == r_frame_cols);
        if (cur_last_col) begin
            n_col = '0;
            n_row = cur_last_row ? '0 : cur_r + ROW_W'(1);
        end else begin
            n_col = cur_c + COL_W'(1);
            n_row = cur_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= 1'b0;
            r_frame_rows <= FR_W'(ROWS_RST);
            r_frame_cols <= FC_W'(COLS_RST);
            r_row        <= '0;
            r_col        <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MODE: begin
                    r_mode <= i_cfg_data[0];
                end
                CFG_ROWS: begin
                    r_frame_rows <= cfg_rows;
                    r_row        <= '0;
                    r_col        <= '0;
                end
                CFG_COLS: begin
                    r_frame_cols <= cfg_cols;
                    r_row        <= '0;
                    r_col        <= '0;
                end
                default: begin
                end
            endcase
        end else if (in_acc) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: line buffer read, {two above, above} in one word
    // ------------------------------------------------------------------
    logic                  r_s1_valid;
    logic                  r_s1_fwd;
    logic [LW-1:0]         r_s1_fwd_data;
    logic [PIXEL_BITS-1:0] r_s1_pix;
    logic [ROW_W-1:0]      r_s1_row;
    logic [COL_W-1:0]      r_s1_col;
    logic                  r_s1_last_row;
    logic                  r_s1_last_col;
    logic                  n_s1_fwd;

    logic [LW-1:0]         ram_rdata;
    logic [LW-1:0]         s1_lines;
    logic [PIXEL_BITS-1:0] s1_above;
    logic [PIXEL_BITS-1:0] s1_two;
    logic [LW-1:0]         s1_wdata;
    logic                  s1_adv;
    logic                  s2_free;

    assign s1_lines = r_s1_fwd ? r_s1_fwd_data : ram_rdata;
    assign s1_above = s1_lines[PIXEL_BITS-1:0];
    assign s1_two   = s1_lines[LW-1:PIXEL_BITS];
    assign s1_wdata = {s1_above, r_s1_pix};
    assign s1_adv   = r_s1_valid && s2_free;

    assign o_pixel_ready = !r_s1_valid || s1_adv;

    // Single-column frames read the entry being written this cycle: bypass
    assign n_s1_fwd = s1_adv && (cur_c == r_s1_col);

    mmf_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_COLS)
    ) u_lines (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_col[AW-1:0]),
        .i_wdata (s1_wdata),
        .i_re    (in_acc),
        .i_raddr (cur_c[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_fwd   <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
            r_s1_fwd   <= n_s1_fwd;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
            r_s1_fwd   <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pix      <= i_pixel;
            r_s1_row      <= cur_r;
            r_s1_col      <= cur_c;
            r_s1_last_row <= cur_last_row;
            r_s1_last_col <= cur_last_col;
            r_s1_fwd_data <= s1_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: window and pending results of one pixel
    // ------------------------------------------------------------------
    logic [WIN_N-1:0][PIXEL_BITS-1:0] r_win;
    logic [RES_N-1:0]                 r_s2_mask;
    logic [ROW_W-1:0]                 r_s2_row;
    logic [COL_W-1:0]                 r_s2_col;
    logic                             r_s2_rge1;
    logic                             r_s2_rge2;
    logic                             r_s2_cge1;
    logic                             r_s2_cge2;
    logic                             r_s2_frame_end;
    logic [RES_N-1:0]                 n_s2_mask;

    logic [RES_N-1:0]      cur_res;
    logic [RES_N-1:0]      rest_res;
    logic                  out_load;
    t_win_sel              win_sel;
    logic [PIXEL_BITS-1:0] red_value;

    // Result order: above-left, above-last, this-row-left, this-row-last
    always_comb begin
        n_s2_mask[0] = (r_s1_row != '0) && (r_s1_col != '0);
        n_s2_mask[1] = (r_s1_row != '0) && r_s1_last_col;
        n_s2_mask[2] = r_s1_last_row && (r_s1_col != '0);
        n_s2_mask[3] = r_s1_last_row && r_s1_last_col;
    end

    assign cur_res  = r_s2_mask & (~r_s2_mask + RES_N'(1));
    assign rest_res = r_s2_mask & ~cur_res;
    assign out_load = (r_s2_mask != '0) && (!o_result_valid || i_result_ready);
    assign s2_free  = (r_s2_mask == '0) || (out_load && (rest_res == '0));

    always_comb begin
        win_sel.use_max = r_mode;
        if (cur_res[0] || cur_res[1]) begin
            win_sel.row_lo = r_s2_rge2 ? 2'd0 : 2'd1;
        end else begin
            win_sel.row_lo = r_s2_rge1 ? 2'd1 : 2'd2;
        end
        if (cur_res[0] || cur_res[2]) begin
            win_sel.col_lo = r_s2_cge2 ? 2'd0 : 2'd1;
        end else begin
            win_sel.col_lo = r_s2_cge1 ? 2'd1 : 2'd2;
        end
    end

    mmf_reduce #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_reduce (
        .i_sel   (win_sel),
        .i_win   (r_win),
        .o_value (red_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_mask <= '0;
        end else if (s1_adv) begin
            r_s2_mask <= n_s2_mask;
        end else if (out_load) begin
            r_s2_mask <= rest_res;
        end
    end

    // Advance window columns left, new column enters on the right
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            for (int a = 0; a < 3; a++) begin
                r_win[a*3]   <= r_win[a*3+1];
                r_win[a*3+1] <= r_win[a*3+2];
            end
            r_win[2]       <= s1_two;
            r_win[5]       <= s1_above;
            r_win[8]       <= r_s1_pix;
            r_s2_row       <= r_s1_row;
            r_s2_col       <= r_s1_col;
            r_s2_rge1      <= (r_s1_row != '0);
            r_s2_rge2      <= (r_s1_row >= ROW_W'(2));
            r_s2_cge1      <= (r_s1_col != '0);
            r_s2_cge2      <= (r_s1_col >= COL_W'(2));
            r_s2_frame_end <= r_s1_last_row && r_s1_last_col;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic                  r_out_valid;
    logic [PIXEL_BITS-1:0] r_out_value;
    logic [ROW_W-1:0]      r_out_row;
    logic [COL_W-1:0]      r_out_col;
    logic                  r_out_last;
    logic                  r_out_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_result_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_value <= red_value;
            r_out_row   <= (cur_res[0] || cur_res[1]) ? r_s2_row - ROW_W'(1) : r_s2_row;
            r_out_col   <= (cur_res[0] || cur_res[2]) ? r_s2_col - COL_W'(1) : r_s2_col;
            r_out_last  <= (rest_res == '0);
            r_out_done  <= (rest_res == '0) && r_s2_frame_end;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_result_row   = r_out_row;
    assign o_result_col   = r_out_col;
    assign o_last_of_run  = r_out_last;
    assign o_frame_done   = r_out_done;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_frame_done |-> o_last_of_run)
        else $error("frame_done without last_of_run");

    a_done_at_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_frame_done |->
            (({1'b0, o_result_row} + FR_W'(1)) == r_frame_rows) &&
            (({1'b0, o_result_col} + FC_W'(1)) == r_frame_cols))
        else $error("frame_done away from the last pixel of the frame");

    a_last_col_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_mask[1] || r_s2_mask[3]) |->
            (({1'b0, r_s2_col} + FC_W'(1)) == r_frame_cols))
        else $error("row-end result pending off the last column");

    a_fwd_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_fwd |-> r_s1_valid)
        else $error("line bypass set with no word in the read stage");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> o_result_valid)
        else $error("result loaded but not presented");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for morphology_3x3_min_max_filter
// Streams frames of pixels through the filter with random idle cycles on both
// sides, and in one test a long receiver hold-off. A behavioral model of the
// line buffers and the 3x3 window works out every expected result word. Each
// result word is then checked field by field against the oldest expectation.
// ----------------------------------------------------------------------------
module tb_top;
    import mmf_pkg::*;

    localparam int PIX_W        = DEF_PIXEL_BITS;
    localparam int MAX_COLS     = DEF_MAX_COLS;
    localparam int MAX_ROWS     = DEF_MAX_ROWS;
    localparam int SETTLE       = 10;     // pipeline depth plus the extra results
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 80;
    localparam int RANDOM_ITEMS = 45;
    localparam int WIDE_COLS    = 20;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last_run;
        logic             frame_end;
    } t_morph_result;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    t_cfg_idx         cfg_idx;
    logic [CFG_W-1:0] cfg_data;
    logic             pixel_valid;
    logic             pixel_ready;
    logic [PIX_W-1:0] pixel;
    logic             result_valid;
    logic             result_ready;
    logic [PIX_W-1:0] result_value;
    logic [ROW_W-1:0] result_row;
    logic [COL_W-1:0] result_col;
    logic             last_of_run;
    logic             frame_done;

    // Model state: two line buffers, the window, the raster position, the registers
    logic [PIX_W-1:0] line_one_up [MAX_COLS];
    logic [PIX_W-1:0] line_two_up [MAX_COLS];
    logic [PIX_W-1:0] win [3][3];
    int unsigned      row_pos;
    int unsigned      col_pos;
    int unsigned      frame_h;
    int unsigned      frame_w;
    logic             take_max;

    t_morph_result    pending_results[$];
    int               err_count = 0;
    int               stall_cnt = 0;
    int               hold_req = 0;
    bit               no_idle = 1'b0;

    morphology_3x3_min_max_filter dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_pixel_valid  (pixel_valid),
        .o_pixel_ready  (pixel_ready),
        .i_pixel        (pixel),
        .o_result_valid (result_valid),
        .i_result_ready (result_ready),
        .o_result_value (result_value),
        .o_result_row   (result_row),
        .o_result_col   (result_col),
        .o_last_of_run  (last_of_run),
        .o_frame_done   (frame_done)
    );

    initial begin : clock_gen
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Reduce window rows row_lo..2 and columns col_lo..2
    function automatic logic [PIX_W-1:0] window_extreme(input int row_lo, input int col_lo);
        logic [PIX_W-1:0] acc;
        acc = win[2][2];
        for (int a = row_lo; a < 3; a++) begin
            for (int b = col_lo; b < 3; b++) begin
                if (take_max ? (win[a][b] > acc) : (win[a][b] < acc)) begin
                    acc = win[a][b];
                end
            end
        end
        return acc;
    endfunction

    function automatic t_morph_result make_result(input logic [PIX_W-1:0] v,
                                                  input int unsigned r, input int unsigned c);
        t_morph_result w;
        w.value     = v;
        w.row       = r[ROW_W-1:0];
        w.col       = c[COL_W-1:0];
        w.last_run  = 1'b0;
        w.frame_end = 1'b0;
        return w;
    endfunction

    function automatic void compute_window_results(input logic [PIX_W-1:0] pix);
        t_morph_result res [RES_N];
        int unsigned   r;
        int unsigned   c;
        int            n;
        int            rlo;
        int            clo_prev;
        int            clo_here;
        bit            last_row;
        bit            last_col;
        r = (row_pos >= frame_h) ? 0 : row_pos;
        c = (col_pos >= frame_w) ? 0 : col_pos;
        last_row = (r + 1 == frame_h);
        last_col = (c + 1 == frame_w);
        n = 0;
        for (int k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = line_two_up[c];
        win[1][2] = line_one_up[c];
        win[2][2] = pix;
        line_two_up[c] = line_one_up[c];
        line_one_up[c] = pix;
        // left border drops column 0 of the window; the right edge drops one more
        clo_prev = (c >= 2) ? 0 : 1;
        clo_here = (c >= 1) ? 1 : 2;
        if (r >= 1) begin
            rlo = (r >= 2) ? 0 : 1;
            if (c >= 1) begin
                res[n] = make_result(window_extreme(rlo, clo_prev), r - 1, c - 1);
                n++;
            end
            if (last_col) begin
                res[n] = make_result(window_extreme(rlo, clo_here), r - 1, c);
                n++;
            end
        end
        // the last row has no row below, so flush it right away
        if (last_row) begin
            rlo = (r >= 1) ? 1 : 2;
            if (c >= 1) begin
                res[n] = make_result(window_extreme(rlo, clo_prev), r, c - 1);
                n++;
            end
            if (last_col) begin
                res[n] = make_result(window_extreme(rlo, clo_here), r, c);
                n++;
            end
        end
        if (n > 0) begin
            res[n-1].last_run  = 1'b1;
            res[n-1].frame_end = last_row && last_col;
        end
        for (int k = 0; k < n; k++) begin
            pending_results.push_back(res[k]);
        end
        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    task automatic check_result();
        t_morph_result want;
        if (pending_results.size() == 0) begin
            report_mismatch("result word with none expected", result_value, '0);
            return;
        end
        want = pending_results.pop_front();
        if (result_value !== want.value)    report_mismatch("value", result_value, want.value);
        if (result_row !== want.row)        report_mismatch("row", result_row, want.row);
        if (result_col !== want.col)        report_mismatch("col", result_col, want.col);
        if (last_of_run !== want.last_run)  report_mismatch("last_of_run", last_of_run,
                                                            want.last_run);
        if (frame_done !== want.frame_end)  report_mismatch("frame_done", frame_done,
                                                            want.frame_end);
    endtask

    always @(posedge clk) begin
        if (rst_n && result_valid && result_ready) begin
            check_result();
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (pixel_valid && pixel_ready) || (result_valid && result_ready)) begin
            stall_cnt <= 0;
        end else if (stall_cnt == STALL_LIMIT) begin
            $display("%0t: timeout, no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    // Result side: draw an idle count per word, or take a requested hold-off
    initial begin : result_sink
        int w;
        result_ready = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (hold_req != 0) begin
                w = hold_req;
                hold_req = 0;
            end else begin
                w = no_idle ? 0 : $urandom_range(0, 4);
            end
            if (w != 0) begin
                result_ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
        end
    end

    // Write one register; drop the enable again after the write
    task automatic write_reg(input t_cfg_idx idx, input int unsigned data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data[CFG_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_MODE: take_max = data[0];
            CFG_ROWS: begin
                frame_h = clamp_size(data[12:0], MAX_ROWS);
                row_pos = 0;
                col_pos = 0;
            end
            CFG_COLS: begin
                frame_w = clamp_size(data[10:0], MAX_COLS);
                row_pos = 0;
                col_pos = 0;
            end
            default: ;
        endcase
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel       <= pix;
        do @(posedge clk); while (!pixel_ready);
        compute_window_results(pix);
    endtask

    task automatic send_pixels(input int count);
        for (int i = 0; i < count; i++) begin
            send_pixel(rand_pixel());
        end
    endtask

    // Drop valid, wait for every expected word, then let the pipeline empty
    task automatic wait_drained();
        pixel_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic test_size_limits();
        // reset size is 4096 x 1024: the first row makes no results
        send_pixel(16'hFFFF);
        send_pixel(16'h0000);
        wait_drained();
        // oversize writes clamp to the maxima
        write_reg(CFG_ROWS, 8191);
        write_reg(CFG_COLS, 8191);
        send_pixel(16'hAAAA);
        send_pixel(16'h5555);
        wait_drained();
        // a size write mid-frame restarts at row 0
        write_reg(CFG_ROWS, 2);
        write_reg(CFG_COLS, 3);
        send_pixel(16'h0001);
        send_pixel(16'h8000);
        send_pixel(16'hFFFF);
        send_pixel(16'h0000);
        send_pixel(16'h7FFF);
        send_pixel(16'h1234);
        wait_drained();
    endtask

    task automatic test_single_pixel_frame();
        // zero sizes clamp to 1: every pixel is a whole frame
        write_reg(CFG_ROWS, 0);
        write_reg(CFG_COLS, 0);
        write_reg(CFG_MODE, 0);
        send_pixel(16'h5555);
        wait_drained();
        write_reg(CFG_MODE, 1);
        send_pixel(16'hAAAA);
        wait_drained();
    endtask

    task automatic test_two_by_two();
        write_reg(CFG_ROWS, 2);
        write_reg(CFG_COLS, 2);
        for (int m = 0; m < 2; m++) begin
            write_reg(CFG_MODE, m);
            send_pixel(16'hFFFF);
            send_pixel(16'h0000);
            send_pixel(16'hAAAA);
            send_pixel(16'h5555);
            wait_drained();
        end
    endtask

    task automatic test_thin_frames();
        write_reg(CFG_MODE, 1);
        write_reg(CFG_ROWS, 1);
        write_reg(CFG_COLS, 3);
        send_pixels(3);
        wait_drained();
        write_reg(CFG_MODE, 0);
        write_reg(CFG_ROWS, 3);
        write_reg(CFG_COLS, 1);
        send_pixels(3);
        wait_drained();
    endtask

    task automatic test_wide_frame();
        write_reg(CFG_MODE, $urandom_range(0, 1));
        write_reg(CFG_ROWS, 2);
        write_reg(CFG_COLS, WIDE_COLS);
        send_pixels(2 * WIDE_COLS);
        wait_drained();
    endtask

    task automatic test_backpressure();
        write_reg(CFG_MODE, $urandom_range(0, 1));
        write_reg(CFG_ROWS, 4);
        write_reg(CFG_COLS, 8);
        no_idle  = 1'b1;
        hold_req = HOLD_CYCLES;
        send_pixels(32);
        no_idle = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_frames();
        int sent;
        int choice;
        int count;
        int remaining;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            choice  = $urandom_range(0, 9);
            no_idle = ($urandom_range(0, 3) == 0);
            write_reg(CFG_MODE, $urandom_range(0, 1));
            // without a size write the frame goes on under the new mode
            if (choice < 7 || choice == 9) begin
                write_reg(CFG_ROWS, (choice == 6) ? $urandom_range(0, 8191)
                                                  : $urandom_range(1, 5));
                write_reg(CFG_COLS, (choice == 6) ? $urandom_range(0, 3)
                                                  : $urandom_range(1, 7));
            end
            remaining = frame_h * frame_w - (row_pos * frame_w + col_pos);
            if (choice < 7) begin
                count = remaining;
                if (count < 12 && $urandom_range(0, 1) == 1) count += frame_h * frame_w;
                if (count > 40) count = 40;
            end else begin
                count = $urandom_range(1, 8);
            end
            send_pixels(count);
            sent += count;
            no_idle = 1'b0;
            wait_drained();
        end
    endtask

    initial begin : main_seq
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_idx     = CFG_MODE;
        cfg_data    = '0;
        pixel_valid = 1'b0;
        pixel       = '0;
        for (int i = 0; i < MAX_COLS; i++) begin
            line_one_up[i] = '0;
            line_two_up[i] = '0;
        end
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
                win[a][b] = '0;
            end
        end
        row_pos  = 0;
        col_pos  = 0;
        frame_h  = MAX_ROWS;
        frame_w  = MAX_COLS;
        take_max = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_size_limits();
        test_single_pixel_frame();
        test_two_by_two();
        test_thin_frames();
        test_wide_frame();
        test_backpressure();
        test_random_frames();
        wait_drained();
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
src/mmf_pkg.sv
src/mmf_ram.sv
src/mmf_reduce.sv
src/morphology_3x3_min_max_filter.sv
tb/tb_top.sv
